@@ rtl/pas_pkg.sv @@
// Package for the polygon area statistics block: fixed field widths,
// saturation limits, request and register codes and the filter mode type.
// Depends on nothing; used by rtl/polygon_area_statistics.sv.
package pas_pkg;

  // Result and statistics widths fixed by the interface.
  localparam int unsigned AREA_W   = 38;
  localparam int unsigned SUM_W    = 63;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned FILTER_W = 2;
  localparam int unsigned EXACT_W  = 7;
  localparam int unsigned CFG_W    = 7;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [AREA_W-1:0] AREA_MAX = '1;
  localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

  // Smallest vertex count that makes a polygon.
  localparam int unsigned MIN_VERTICES = 3;

  // Request codes carried in the req_type field.
  localparam logic REQ_VERTEX = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXACT_COUNT = 1'b1;

  localparam logic [EXACT_W-1:0] EXACT_RESET = 7'd3;

  typedef enum logic [FILTER_W-1:0] {
    FILT_ALL   = 2'd0,
    FILT_ODD   = 2'd1,
    FILT_EVEN  = 2'd2,
    FILT_EXACT = 2'd3
  } filter_mode_e;

endpackage

@@ rtl/polygon_area_statistics.sv @@
// Top level of the polygon area statistics block: a five-register pipeline
// that accumulates shoelace cross products and keeps running statistics.
// Depends on rtl/pas_pkg.sv.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------------
//  in      | to block  | in_valid_i / in_ready_o | req_type, coord_x, coord_y, last_vertex
//  out     | from block| out_valid_o / out_ready_i | twice_area, vertices, flags, statistics
//  cfg     | to block  | cfg_we_i (no wait)      | cfg_idx_i, cfg_data_i
//
// One beat is accepted per clock cycle unless out_ready_i holds the pipeline back.
// A result beat passes the input, product, cross sum, area and result
// registers in that order after the beat of its closing vertex is accepted.
// Plain vertices and clear requests produce no result beat. Reset clears the
// control state and the statistics at once; there is no clearing pass. While
// a result waits on out_ready_i, clear requests still drain and later beats
// queue in the free pipeline registers before in_ready_o falls.
module polygon_area_statistics #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned COORD_BITS   = 16,
  localparam int unsigned VTX_W       = $clog2(MAX_VERTICES + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           req_type_i,
  input  logic signed [COORD_BITS-1:0]   coord_x_i,
  input  logic signed [COORD_BITS-1:0]   coord_y_i,
  input  logic                           last_vertex_i,

  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [pas_pkg::AREA_W-1:0]     twice_area_o,
  output logic [VTX_W-1:0]               vertices_o,
  output logic                           polygon_valid_o,
  output logic                           filter_hit_o,
  output logic [pas_pkg::SUM_W-1:0]      filtered_sum_o,
  output logic [pas_pkg::CNT_W-1:0]      hit_count_o,
  output logic [pas_pkg::CNT_W-1:0]      polygon_total_o,
  output logic [pas_pkg::AREA_W-1:0]     largest_area_o,
  output logic [pas_pkg::AREA_W-1:0]     smallest_area_o,
  output logic [VTX_W-1:0]               most_vertices_o,
  output logic [VTX_W-1:0]               fewest_vertices_o,

  input  logic                           cfg_we_i,
  input  logic [pas_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pas_pkg::CFG_W-1:0]      cfg_data_i
);

  import pas_pkg::*;

  // Each cross product needs twice the coordinate width. The running sum holds
  // up to MAX_VERTICES differences of two products, plus a sign bit.
  localparam int unsigned PROD_W  = 2 * COORD_BITS;
  localparam int unsigned CROSS_W = PROD_W + $clog2(MAX_VERTICES + 1) + 1;
  localparam int unsigned MAG_W   = (CROSS_W > AREA_W) ? CROSS_W : AREA_W;
  localparam int unsigned CMP_W   = (VTX_W > EXACT_W) ? VTX_W : EXACT_W;

  localparam logic [VTX_W-1:0] VTX_MAX = VTX_W'(MAX_VERTICES);
  localparam logic [VTX_W-1:0] VTX_MIN = VTX_W'(MIN_VERTICES);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  filter_mode_e        filter_mode_q;
  logic [EXACT_W-1:0]  exact_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_mode_q <= FILT_ALL;
      exact_count_q <= EXACT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FILTER_MODE: filter_mode_q <= filter_mode_e'(cfg_data_i[FILTER_W-1:0]);
        CFG_EXACT_COUNT: exact_count_q <= cfg_data_i[EXACT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control. Stage one holds the accepted beat, stage two the
  // products, stage three the closed cross sum, stage four the area. A plain
  // vertex retires in stage two once its products are accumulated; a clear
  // retires in stage four without using the result register.
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, out_valid_q;
  logic go1, go2, go3, go4;

  logic                         s1_clr_q, s1_last_q;
  logic signed [COORD_BITS-1:0] s1_x_q, s1_y_q;

  logic                         s2_clr_q, s2_last_q, s2_add_q, s2_valid_q;
  logic [VTX_W-1:0]             s2_n_q;
  logic signed [PROD_W-1:0]     s2_pa_q, s2_pb_q, s2_pc_q, s2_pd_q;

  logic                         s3_clr_q, s3_valid_q;
  logic [VTX_W-1:0]             s3_n_q;
  logic signed [CROSS_W-1:0]    s3_sum_q;

  logic                         s4_clr_q, s4_valid_q;
  logic [VTX_W-1:0]             s4_n_q;
  logic [AREA_W-1:0]            s4_area_q;

  assign go4 = v4_q && (s4_clr_q || !out_valid_q || out_ready_i);
  assign go3 = v3_q && (!v4_q || go4);
  assign go2 = v2_q && ((!s2_clr_q && !s2_last_q) || !v3_q || go3);
  assign go1 = v1_q && (!v2_q || go2);

  assign in_ready_o = !v1_q || go1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        v1_q <= in_valid_i;
      end
      if (!v2_q || go2) begin
        v2_q <= go1;
      end
      if (!v3_q || go3) begin
        v3_q <= go2 && (s2_clr_q || s2_last_q);
      end
      if (!v4_q || go4) begin
        v4_q <= go3;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage one: input register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_clr_q  <= (req_type_i == REQ_CLEAR);
      s1_last_q <= last_vertex_i;
      s1_x_q    <= coord_x_i;
      s1_y_q    <= coord_y_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Polygon bookkeeping and the four products. The first vertex is captured,
  // the previous vertex follows every vertex within the limit, and vertices
  // past the limit only mark the polygon as overflowed. The closing term uses
  // the first and previous vertex as they stand after this vertex.
  // ---------------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic signed [COORD_BITS-1:0] first_x_d, first_y_d, prev_x_d, prev_y_d;
  logic [VTX_W-1:0]             tally_q, tally_d;
  logic                         ovf_q, ovf_d;
  logic                         in_range, add_term, poly_valid;

  always_comb begin
    in_range  = (tally_q < VTX_MAX);
    add_term  = in_range && (tally_q != '0);
    first_x_d = first_x_q;
    first_y_d = first_y_q;
    prev_x_d  = prev_x_q;
    prev_y_d  = prev_y_q;
    tally_d   = tally_q;
    if (in_range) begin
      if (tally_q == '0) begin
        first_x_d = s1_x_q;
        first_y_d = s1_y_q;
      end
      prev_x_d = s1_x_q;
      prev_y_d = s1_y_q;
      tally_d  = tally_q + VTX_W'(1);
    end
    ovf_d      = ovf_q || !in_range;
    poly_valid = !ovf_d && (tally_d >= VTX_MIN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_x_q <= '0;
      first_y_q <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      tally_q   <= '0;
      ovf_q     <= 1'b0;
    end else if (go1 && !s1_clr_q) begin
      first_x_q <= first_x_d;
      first_y_q <= first_y_d;
      prev_x_q  <= prev_x_d;
      prev_y_q  <= prev_y_d;
      // A closed polygon starts the next one afresh.
      tally_q   <= s1_last_q ? '0 : tally_d;
      ovf_q     <= s1_last_q ? 1'b0 : ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go1) begin
      s2_clr_q   <= s1_clr_q;
      s2_last_q  <= s1_last_q;
      s2_add_q   <= add_term;
      s2_n_q     <= tally_d;
      s2_valid_q <= poly_valid;
      s2_pa_q    <= PROD_W'(prev_x_q) * PROD_W'(s1_y_q);
      s2_pb_q    <= PROD_W'(prev_y_q) * PROD_W'(s1_x_q);
      s2_pc_q    <= PROD_W'(prev_x_d) * PROD_W'(first_y_d);
      s2_pd_q    <= PROD_W'(prev_y_d) * PROD_W'(first_x_d);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage two: accumulate the cross sum; a closing vertex hands the total on, a clear passes on.
  // ---------------------------------------------------------------------------
  logic signed [CROSS_W-1:0] cross_q, cross_total;
  logic signed [CROSS_W-1:0] step_term, close_term;

  always_comb begin
    step_term   = s2_add_q ? (CROSS_W'(s2_pa_q) - CROSS_W'(s2_pb_q)) : '0;
    close_term  = s2_last_q ? (CROSS_W'(s2_pc_q) - CROSS_W'(s2_pd_q)) : '0;
    cross_total = cross_q + step_term + close_term;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cross_q <= '0;
    end else if (go2 && !s2_clr_q) begin
      cross_q <= s2_last_q ? '0 : cross_total;
    end
  end

  // Only beats that move on to stage three load it, so a plain vertex retiring
  // here never disturbs a beat held there.
  always_ff @(posedge clk_i) begin
    if (go2 && (s2_clr_q || s2_last_q)) begin
      s3_clr_q   <= s2_clr_q;
      s3_valid_q <= s2_valid_q;
      s3_n_q     <= s2_n_q;
      s3_sum_q   <= cross_total;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage three: magnitude and saturation. An invalid polygon reports zero.
  // ---------------------------------------------------------------------------
  logic [CROSS_W-1:0] cross_mag;
  logic [MAG_W-1:0]   mag_ext;
  logic [AREA_W-1:0]  area_d;

  always_comb begin
    cross_mag = s3_sum_q[CROSS_W-1] ? (CROSS_W'(0) - CROSS_W'(s3_sum_q))
                                    : CROSS_W'(s3_sum_q);
    mag_ext   = MAG_W'(cross_mag);
    if (!s3_valid_q) begin
      area_d = '0;
    end else if (mag_ext > MAG_W'(AREA_MAX)) begin
      area_d = AREA_MAX;
    end else begin
      area_d = mag_ext[AREA_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (go3) begin
      s4_clr_q   <= s3_clr_q;
      s4_valid_q <= s3_valid_q;
      s4_n_q     <= s3_n_q;
      s4_area_q  <= area_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage four: statistics. A clear returns them to their reset values; a
  // valid polygon updates them; an invalid one leaves them as they are.
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  hits_q, hits_d, polys_q, polys_d;
  logic [AREA_W-1:0] max_area_q, max_area_d, min_area_q, min_area_d;
  logic [VTX_W-1:0]  most_q, most_d, fewest_q, fewest_d;
  logic [SUM_W:0]    sum_wide;
  logic              hit;

  always_comb begin
    case (filter_mode_q)
      FILT_ALL:   hit = 1'b1;
      FILT_ODD:   hit = s4_n_q[0];
      FILT_EVEN:  hit = !s4_n_q[0];
      FILT_EXACT: hit = (CMP_W'(s4_n_q) == CMP_W'(exact_count_q));
      default:    hit = 1'b0;
    endcase
    hit = hit && s4_valid_q;

    sum_wide   = (SUM_W + 1)'(sum_q) + (SUM_W + 1)'(s4_area_q);
    sum_d      = sum_q;
    hits_d     = hits_q;
    polys_d    = polys_q;
    max_area_d = max_area_q;
    min_area_d = min_area_q;
    most_d     = most_q;
    fewest_d   = fewest_q;

    if (s4_clr_q) begin
      sum_d      = '0;
      hits_d     = '0;
      polys_d    = '0;
      max_area_d = '0;
      min_area_d = AREA_MAX;
      most_d     = '0;
      fewest_d   = VTX_MAX;
    end else if (s4_valid_q) begin
      if (polys_q != CNT_MAX) begin
        polys_d = polys_q + CNT_W'(1);
      end
      if (s4_area_q > max_area_q) begin
        max_area_d = s4_area_q;
      end
      if (s4_area_q < min_area_q) begin
        min_area_d = s4_area_q;
      end
      if (s4_n_q > most_q) begin
        most_d = s4_n_q;
      end
      if (s4_n_q < fewest_q) begin
        fewest_d = s4_n_q;
      end
      if (hit) begin
        sum_d = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
        if (hits_q != CNT_MAX) begin
          hits_d = hits_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q      <= '0;
      hits_q     <= '0;
      polys_q    <= '0;
      max_area_q <= '0;
      min_area_q <= AREA_MAX;
      most_q     <= '0;
      fewest_q   <= VTX_MAX;
    end else if (go4) begin
      sum_q      <= sum_d;
      hits_q     <= hits_d;
      polys_q    <= polys_d;
      max_area_q <= max_area_d;
      min_area_q <= min_area_d;
      most_q     <= most_d;
      fewest_q   <= fewest_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register. It keeps its own copy of the statistics so that a clear
  // passing behind a waiting result does not change that result.
  // ---------------------------------------------------------------------------
  logic load_out;

  assign load_out = go4 && !s4_clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      twice_area_o      <= s4_area_q;
      vertices_o        <= s4_n_q;
      polygon_valid_o   <= s4_valid_q;
      filter_hit_o      <= hit;
      filtered_sum_o    <= sum_d;
      hit_count_o       <= hits_d;
      polygon_total_o   <= polys_d;
      largest_area_o    <= max_area_d;
      smallest_area_o   <= min_area_d;
      most_vertices_o   <= most_d;
      fewest_vertices_o <= fewest_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_hit_needs_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && filter_hit_o |-> polygon_valid_o)
    else $error("filter hit reported for an invalid polygon");

  a_invalid_zero_area : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !polygon_valid_o |-> twice_area_o == '0)
    else $error("invalid polygon reported a non-zero area");

  a_hits_within_total : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hit_count_o <= polygon_total_o)
    else $error("hit count exceeds polygon total");

  a_extremes_ordered : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && polygon_total_o != '0 |->
      smallest_area_o <= largest_area_o && fewest_vertices_o <= most_vertices_o)
    else $error("minimum statistics exceed maximum statistics");

endmodule
